// ===== sv/bytc_pkg.sv =====
package bytc_pkg;

  localparam int SetDepth  = 128;
  localparam int IdxW      = $clog2(SetDepth);
  localparam int CntW      = $clog2(SetDepth + 1);
  localparam int ByteW     = 8;
  localparam int CountW    = 8;
  localparam int ReqW      = 2;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 8;
  localparam int GrpSize   = 8;
  localparam int GrpIdxW   = $clog2(GrpSize);
  localparam int NumGrp    = SetDepth / GrpSize;
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [ReqW-1:0] {
    REQ_DATA = 2'd0,
    REQ_FROM = 2'd1,
    REQ_TO   = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NEGATE     = 2'd0,
    CFG_FROM_COUNT = 2'd1,
    CFG_TO_COUNT   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_LOAD = 3'd0,
    OP_PASS = 3'd1,
    OP_MAP  = 3'd2,
    OP_TAIL = 3'd3,
    OP_DROP = 3'd4
  } op_e;

  typedef struct packed {
    logic              negate;
    logic [CountW-1:0] from_count;
    logic [CountW-1:0] to_count;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    logic [IdxW-1:0]  addr;
    logic [ByteW-1:0] data;
  } qent_t;

endpackage

// ===== sv/bytc_if.sv =====
interface bytc_in_if;
  import bytc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ReqW-1:0]  req_type;
  logic [IdxW-1:0]  slot;
  logic [ByteW-1:0] value;
  modport source (output valid, output req_type, output slot, output value, input ready);
  modport sink (input valid, input req_type, input slot, input value, output ready);
endinterface

interface bytc_out_if;
  import bytc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  modport source (output valid, output out_byte, input ready);
  modport sink (input valid, input out_byte, output ready);
endinterface

interface bytc_cfg_if;
  import bytc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/byte_transliterate_collapse_core.sv =====
// byte transliteration filter with run collapsing
// in_i carries requests: a data byte, a from-set entry or a to-set entry;
// out_o carries the mapped bytes, at most one per data byte; cfg_i writes
// negate, from_count and to_count and is always ready, to be used only
// while no data is in flight.
// a from-set entry is compared by its own cell, so it counts for the very
// next beat; to-set entries go through the queue in order with the data.
// on its way from in_i to out_o a beat passes the compare cells and group
// encode into the stage-one register, the position select into the queue,
// and the to-set memory read into the output register.
// one request is taken per cycle while the four-entry queue has room.
// a stalled receiver holds the output register, then fills the queue, and
// only then drops in_i.ready.
// reset clears the run flag, the counters and all valid flags and sets the
// config registers to zero; the set tables hold no defined value until loaded.
module byte_transliterate_collapse_core (
  input  logic    clk_i,
  input  logic    rst_ni,
  bytc_in_if.sink  in_i,
  bytc_out_if.source out_o,
  bytc_cfg_if.sink cfg_i
);
  import bytc_pkg::*;

  cfg_t  cfg_q;
  logic  q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  qent_t q_push_data, q_pop_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_NEGATE:     cfg_q.negate     <= cfg_i.data[0];
        CFG_FROM_COUNT: cfg_q.from_count <= CountW'(cfg_i.data);
        CFG_TO_COUNT:   cfg_q.to_count   <= CountW'(cfg_i.data);
        default:        cfg_q            <= cfg_q;
      endcase
    end
  end

  bytc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_i     (cfg_q),
    .q_valid_o (q_push_valid),
    .q_ready_i (q_push_ready),
    .q_data_o  (q_push_data)
  );

  bytc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_data_i  (q_push_data),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data)
  );

  bytc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_pop_valid),
    .pop_ready_o (q_pop_ready),
    .pop_data_i  (q_pop_data),
    .out_o       (out_o)
  );

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_valid && q_pop_ready &&
     ((q_pop_data.op == OP_PASS) || (q_pop_data.op == OP_MAP))) |=> out_o.valid)
    else $error("passed or mapped byte did not reach the output");

  a_silent_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_valid && q_pop_ready &&
     ((q_pop_data.op == OP_LOAD) || (q_pop_data.op == OP_DROP))) |=> !out_o.valid)
    else $error("load or deleted byte produced an output beat");

  a_front_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push_valid && !q_push_ready) |=> (q_push_valid && $stable(q_push_data)))
    else $error("front stage changed while the queue was full");

endmodule

// ===== sv/bytc_front.sv =====
module bytc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  bytc_in_if.sink        in_i,
  input  bytc_pkg::cfg_t cfg_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output bytc_pkg::qent_t q_data_o
);
  import bytc_pkg::*;

  logic [ByteW-1:0] from_q [SetDepth];

  logic               s1_valid_q, s1_valid_d;
  req_e               s1_req_q;
  logic [IdxW-1:0]    s1_slot_q;
  logic [ByteW-1:0]   s1_value_q;
  logic [NumGrp-1:0]  s1_hit_q, hit_d;
  logic [GrpIdxW-1:0] s1_lidx_q [NumGrp];
  logic [GrpIdxW-1:0] lidx_d [NumGrp];

  logic            accept;
  req_e            in_req;
  logic [CntW-1:0] nfrom, nto;
  logic            has_to, collapse, found;
  logic [IdxW-1:0] last_to, pos;

  assign in_req    = req_e'(in_i.req_type);
  assign in_i.ready = !s1_valid_q || q_ready_i;
  assign accept    = in_i.valid && in_i.ready;
  assign q_valid_o = s1_valid_q;

  assign nfrom = (cfg_i.from_count > CountW'(SetDepth)) ? CntW'(SetDepth)
                                                         : CntW'(cfg_i.from_count);
  assign nto   = (cfg_i.to_count > CountW'(SetDepth)) ? CntW'(SetDepth)
                                                       : CntW'(cfg_i.to_count);
  assign has_to   = (nto != '0);
  assign last_to  = IdxW'(nto - CntW'(1));
  assign collapse = (nfrom > nto) || cfg_i.negate;

  // compare cells, first hit within each group of eight
  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      hit_d[g]  = 1'b0;
      lidx_d[g] = '0;
      for (int j = GrpSize - 1; j >= 0; j--) begin
        if ((from_q[g*GrpSize + j] == in_i.value) &&
            (CntW'(g*GrpSize + j) < nfrom)) begin
          hit_d[g]  = 1'b1;
          lidx_d[g] = GrpIdxW'(j);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (in_req == REQ_FROM)) begin
      from_q[in_i.slot] <= in_i.value;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept && ((in_req == REQ_DATA) || (in_req == REQ_TO))) begin
      s1_valid_d = 1'b1;
    end else if (q_ready_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && ((in_req == REQ_DATA) || (in_req == REQ_TO))) begin
      s1_req_q   <= in_req;
      s1_slot_q  <= in_i.slot;
      s1_value_q <= in_i.value;
      s1_hit_q   <= hit_d;
      s1_lidx_q  <= lidx_d;
    end
  end

  // first group with a hit gives the from-set position
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int g = NumGrp - 1; g >= 0; g--) begin
      if (s1_hit_q[g]) begin
        found = 1'b1;
        pos   = IdxW'(g*GrpSize) | IdxW'(s1_lidx_q[g]);
      end
    end
  end

  always_comb begin
    q_data_o.op   = OP_PASS;
    q_data_o.addr = pos;
    q_data_o.data = s1_value_q;
    if (s1_req_q == REQ_TO) begin
      q_data_o.op   = OP_LOAD;
      q_data_o.addr = s1_slot_q;
    end else if (s1_value_q == '0) begin
      q_data_o.op = OP_PASS;
    end else if (cfg_i.negate) begin
      if (found) begin
        q_data_o.op = OP_PASS;
      end else if (has_to) begin
        q_data_o.op   = OP_TAIL;
        q_data_o.addr = last_to;
      end else begin
        q_data_o.op = OP_DROP;
      end
    end else if (found) begin
      if (collapse && has_to && (pos >= last_to)) begin
        q_data_o.op   = OP_TAIL;
        q_data_o.addr = last_to;
      end else if (has_to) begin
        q_data_o.op = OP_MAP;
      end else begin
        q_data_o.op = OP_DROP;
      end
    end
  end

endmodule

// ===== sv/bytc_fifo.sv =====
module bytc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  bytc_pkg::qent_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output bytc_pkg::qent_t pop_data_o
);
  import bytc_pkg::*;

  qent_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] count_q, count_d;
  logic                push, pop;

  assign push_ready_o = (count_q != FifoCntW'(FifoDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + FifoCntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/bytc_back.sv =====
module bytc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  bytc_pkg::qent_t pop_data_i,
  bytc_out_if.source      out_o
);
  import bytc_pkg::*;

  logic [ByteW-1:0] to_mem [SetDepth];
  logic [ByteW-1:0] rd_q, byte_q;
  logic             sel_mem_q;
  logic             out_valid_q, out_valid_d;
  logic             in_run_q, in_run_d;
  logic             pop, emit, use_mem;

  assign pop_ready_o = !out_valid_q || out_o.ready;
  assign pop = pop_valid_i && pop_ready_o;

  always_comb begin
    emit     = 1'b0;
    use_mem  = 1'b0;
    in_run_d = in_run_q;
    case (pop_data_i.op)
      OP_PASS: begin
        emit     = 1'b1;
        in_run_d = 1'b0;
      end
      OP_MAP: begin
        emit     = 1'b1;
        use_mem  = 1'b1;
        in_run_d = 1'b0;
      end
      // rest of a collapsed run is swallowed
      OP_TAIL: begin
        emit     = !in_run_q;
        use_mem  = 1'b1;
        in_run_d = 1'b1;
      end
      OP_DROP: begin
        in_run_d = 1'b0;
      end
      default: begin
        in_run_d = in_run_q;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = emit;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      in_run_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        in_run_q <= in_run_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && (pop_data_i.op == OP_LOAD)) begin
      to_mem[pop_data_i.addr] <= pop_data_i.data;
    end
    if (pop && emit && use_mem) begin
      rd_q <= to_mem[pop_data_i.addr];
    end
    if (pop && emit) begin
      sel_mem_q <= use_mem;
      byte_q    <= pop_data_i.data;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = sel_mem_q ? rd_q : byte_q;

endmodule
